>>> hw/rtl/wosc_pkg.sv
// shared constants and types of the waveform oscillator
package wosc_pkg;

  // default sizes
  localparam int DEF_PHASE_BITS       = 32;
  localparam int DEF_SAMPLE_BITS      = 16;
  localparam int DEF_SINE_TABLE_DEPTH = 256;

  // configuration port widths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // half pi in Q30, used by the table builder
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WAVE_MODE  = 2'd0,
    CFG_PHASE_STEP = 2'd1,
    CFG_MUTE       = 2'd2
  } cfg_idx_t;

  // waveform select codes
  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SAW      = 2'd1,
    WAVE_SQUARE   = 2'd2,
    WAVE_TRIANGLE = 2'd3
  } wave_t;

endpackage

>>> hw/rtl/wosc_sine_rom.sv
// quarter-wave sine rom, contents built at elaboration, registered read
module wosc_sine_rom import wosc_pkg::*; #(
  parameter int SAMPLE_BITS      = DEF_SAMPLE_BITS,
  parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH
) (
  input  logic                                  clk,
  input  logic                                  rd_en,
  input  logic [$clog2(SINE_TABLE_DEPTH+1)-1:0] rd_addr,
  output logic [SAMPLE_BITS-1:0]                rd_data
);

  localparam int FracBits = SAMPLE_BITS - 1;
  localparam int Entries  = SINE_TABLE_DEPTH + 1;

  typedef logic [SAMPLE_BITS-1:0] rom_t [Entries];

  // sin(pi/2 * i / depth) in Q1.F, by a fixed Q30 taylor series
  function automatic rom_t build_rom();
    rom_t               tab;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        v;
    logic signed [63:0] sum;
    for (int i = 0; i < Entries; i++) begin
      x    = (HALF_PI_Q30 * 64'(i)) / 64'(SINE_TABLE_DEPTH);
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (int k = 1; k <= 7; k++) begin
        term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if (k[0]) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = '0;
      end
      v = ((64'(sum) << FracBits) + (64'd1 << 29)) >> 30;
      if (v > (64'd1 << FracBits)) begin
        v = 64'd1 << FracBits;
      end
      tab[i] = v[SAMPLE_BITS-1:0];
    end
    return tab;
  endfunction

  localparam rom_t SineRom = build_rom();

  // synchronous read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= SineRom[rd_addr];
    end
  end

endmodule

>>> hw/rtl/waveform_oscillator_unit.sv
// top level of the phase accumulator waveform oscillator
//
// Each transaction on the input channel with in_sample_request set yields one
// signed Q1.F sample on the output channel (F = SAMPLE_BITS-1), computed from
// the current phase, after which phase_step is added to the phase modulo
// 2^PHASE_BITS; a transaction with the request bit clear yields nothing and
// leaves the phase alone. The block takes one transaction per clock unless the
// output stalls with stage 1 full. The phase add, ramp shapes and sine rom
// address come before the stage 1 registers and the registered rom read, and
// the final select feeds the output register. The rom is a constant
// quarter-wave table of SINE_TABLE_DEPTH+1 entries and needs no fill after
// reset. Mute forces the sample to zero and freezes the phase. Configuration
// writes are taken every cycle and belong while no sample is pending.
module waveform_oscillator_unit import wosc_pkg::*; #(
  parameter int PHASE_BITS       = DEF_PHASE_BITS,
  parameter int SAMPLE_BITS      = DEF_SAMPLE_BITS,
  parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  // sample requests
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_sample_request,
  // samples
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample_value
);

  localparam int FracBits = SAMPLE_BITS - 1;
  localparam int AddrW    = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int StepW    = (PHASE_BITS > CFG_DATA_W) ? PHASE_BITS : CFG_DATA_W;
  localparam int QuarterW = PHASE_BITS - 2;
  localparam int ProdW    = QuarterW + AddrW;

  localparam logic [SAMPLE_BITS-1:0] SmpMax = {1'b0, {FracBits{1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SmpMin = {1'b1, {FracBits{1'b0}}};
  localparam logic [SAMPLE_BITS:0]   OneW   = {2'b01, {FracBits{1'b0}}};
  localparam logic [PHASE_BITS-1:0]  HalfTurn = {1'b1, {(PHASE_BITS-1){1'b0}}};

  // configuration registers
  wave_t                 mode_r;
  logic [CFG_DATA_W-1:0] step_r;
  logic                  mute_r;

  // phase accumulator
  logic [PHASE_BITS-1:0] phase_r;
  logic [StepW-1:0]      step_ext;

  // handshake
  logic pipe_move;
  logic in_acc;
  logic s0_load;

  // stage 0 shaping
  logic [FracBits:0]        ratio;
  logic [SAMPLE_BITS:0]     saw_full;
  logic [FracBits:0]        tri_abs;
  logic [SAMPLE_BITS+1:0]   tri_full;
  logic [SAMPLE_BITS-1:0]   saw_val;
  logic [SAMPLE_BITS-1:0]   sq_val;
  logic [SAMPLE_BITS-1:0]   tri_val;
  logic [SAMPLE_BITS-1:0]   lin_val;
  logic                     use_rom;
  logic [QuarterW-1:0]      quarter_ph;
  logic [ProdW-1:0]         k_prod;
  logic [AddrW-1:0]         k_idx;
  logic [AddrW-1:0]         rom_addr;
  logic [SAMPLE_BITS-1:0]   rom_data;

  // stage 1
  logic                     s1_valid_r;
  logic                     s1_use_rom_r;
  logic                     s1_neg_r;
  logic [SAMPLE_BITS-1:0]   s1_lin_r;
  logic [SAMPLE_BITS:0]     rom_ext;
  logic [SAMPLE_BITS:0]     rom_neg;
  logic [SAMPLE_BITS-1:0]   sine_val;
  logic [SAMPLE_BITS-1:0]   smp_nxt;

  // output register
  logic                     out_valid_r;
  logic [SAMPLE_BITS-1:0]   out_smp_r;

  // config writes, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= WAVE_SINE;
      step_r <= '0;
      mute_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WAVE_MODE:  mode_r <= wave_t'(cfg_data[1:0]);
        CFG_PHASE_STEP: step_r <= cfg_data;
        CFG_MUTE:       mute_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  assign pipe_move = !out_valid_r || out_ready;
  assign in_ready  = pipe_move || !s1_valid_r;
  assign in_acc    = in_valid && in_ready;
  assign s0_load   = in_acc && in_sample_request;

  // phase advance after each unmuted sample
  assign step_ext = StepW'(step_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (s0_load && !mute_r) begin
      phase_r <= phase_r + step_ext[PHASE_BITS-1:0];
    end
  end

  // phase over half a turn in Q1.F
  generate
    if (PHASE_BITS - 1 >= FracBits) begin : g_ratio_shr
      assign ratio = phase_r[PHASE_BITS-1 -: SAMPLE_BITS];
    end else begin : g_ratio_shl
      assign ratio = {phase_r, {(SAMPLE_BITS - PHASE_BITS){1'b0}}};
    end
  endgenerate

  // saw, square and triangle shapes, +1.0 saturated
  assign saw_full = OneW - {1'b0, ratio};
  assign saw_val  = (ratio == '0) ? SmpMax : saw_full[SAMPLE_BITS-1:0];
  assign sq_val   = (!phase_r[PHASE_BITS-1] || phase_r == HalfTurn) ? SmpMax : SmpMin;
  assign tri_abs  = ratio[FracBits] ? {1'b0, ratio[FracBits-1:0]}
                                    : OneW[FracBits:0] - ratio;
  assign tri_full = {1'b0, tri_abs, 1'b0} - {1'b0, OneW};
  assign tri_val  = (ratio == '0) ? SmpMax : tri_full[SAMPLE_BITS-1:0];

  always_comb begin
    lin_val = '0;
    use_rom = 1'b0;
    if (!mute_r) begin
      case (mode_r)
        WAVE_SINE:     use_rom = 1'b1;
        WAVE_SAW:      lin_val = saw_val;
        WAVE_SQUARE:   lin_val = sq_val;
        WAVE_TRIANGLE: lin_val = tri_val;
        default:       lin_val = '0;
      endcase
    end
  end

  // sine rom address from quadrant and phase within it
  assign quarter_ph = phase_r[QuarterW-1:0];
  assign k_prod     = ProdW'(quarter_ph) * ProdW'(SINE_TABLE_DEPTH);
  assign k_idx      = k_prod[ProdW-1:QuarterW];
  assign rom_addr   = phase_r[PHASE_BITS-2] ? AddrW'(SINE_TABLE_DEPTH) - k_idx : k_idx;

  wosc_sine_rom #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_rom (
    .clk     (clk),
    .rd_en   (s0_load),
    .rd_addr (rom_addr),
    .rd_data (rom_data)
  );

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= s0_load;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_load) begin
      s1_use_rom_r <= use_rom;
      s1_neg_r     <= phase_r[PHASE_BITS-1];
      s1_lin_r     <= lin_val;
    end
  end

  // sine sign and saturation, final select
  assign rom_ext  = {1'b0, rom_data};
  assign rom_neg  = ~rom_ext + (SAMPLE_BITS+1)'(1);
  assign sine_val = s1_neg_r ? rom_neg[SAMPLE_BITS-1:0]
                             : (rom_data[FracBits] ? SmpMax : rom_data);
  assign smp_nxt  = s1_use_rom_r ? sine_val : s1_lin_r;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pipe_move) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_move && s1_valid_r) begin
      out_smp_r <= smp_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_value = $signed(out_smp_r);

endmodule

>>> hw/rtl/wosc_checker.sv
// port-level checks for the waveform oscillator, bound to the top level
module wosc_checker import wosc_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [CFG_IDX_W-1:0]          cfg_index,
  input logic [CFG_DATA_W-1:0]         cfg_data,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_sample_request,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] out_sample_value
);

  logic [1:0] pending_r;
  logic       mute_sh_r;
  logic       req_acc;
  logic       out_acc;

  assign req_acc = in_valid && in_ready && in_sample_request;
  assign out_acc = out_valid && out_ready;

  // requests not yet answered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else if (req_acc && !out_acc) begin
      pending_r <= pending_r + 2'd1;
    end else if (!req_acc && out_acc) begin
      pending_r <= pending_r - 2'd1;
    end
  end

  // shadow of the mute register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mute_sh_r <= 1'b0;
    end else if (cfg_valid && cfg_ready && cfg_index == CFG_MUTE) begin
      mute_sh_r <= cfg_data[0];
    end
  end

  // a stalled sample holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_value))
    else $error("stalled sample changed or dropped");

  // no sample without a request
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 2'd0)
    else $error("sample without a pending request");

  // at most two requests in flight
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r != 2'd3)
    else $error("more requests in flight than pipeline stages");

  // muted samples are zero
  a_mute_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && mute_sh_r |-> out_sample_value == '0)
    else $error("muted sample not zero");

endmodule

bind waveform_oscillator_unit wosc_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_wosc_checker (.*);
